// ===== sv/tpss_pkg.sv =====
package tpss_pkg;

  localparam int unsigned ValueW  = 24;
  localparam int unsigned PosW    = 23;
  localparam int unsigned OffW    = 25;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned PrecW   = 23;
  localparam int unsigned BoundW  = 26;

  localparam logic [PrecW-1:0] PrecReset = 23'd100;

  typedef enum logic [ModeW-1:0] {
    MODE_VALUE = 2'd0,
    MODE_FWD   = 2'd1,
    MODE_BWD   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic is_query;
    logic out_busy;
  } status_t;

endpackage

// ===== sv/tpss_ctrl.sv =====
module tpss_ctrl
  import tpss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last entry read is evaluated in this cycle.
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!(status_i.is_query && status_i.out_busy)) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/tpss_dp.sv =====
module tpss_dp
  import tpss_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic [ModeW-1:0]  in_mode_i,
  input  logic [ValueW-1:0] in_value_i,
  input  logic              cfg_we_i,
  input  logic [PrecW-1:0]  cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_found_o,
  output logic [PosW-1:0]   out_position_o,
  output logic [OffW-1:0]   out_offset_o,
  output logic              out_overflow_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [PosW-1:0]  mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic             dropped_q;
  logic [PrecW-1:0] prec_q;

  logic [ModeW-1:0]         mode_q;
  logic signed [ValueW-1:0] value_q;
  logic signed [BoundW-1:0] lo_q, hi_q;
  logic [AW-1:0]            addr_q;

  logic            rd_en_q, rd_valid_q;
  logic [AW-1:0]   rd_idx_q;
  logic [PosW-1:0] rd_data_q;

  logic            any_q, hit_q, free_found_q;
  logic [PosW-1:0] mn_q, mx_q, best_q;
  logic [AW-1:0]   free_idx_q;

  logic            out_valid_q, out_found_q, out_overflow_q;
  logic [PosW-1:0] out_position_q;
  logic [OffW-1:0] out_offset_q;

  logic [ValueW-1:0]        mag;
  logic signed [BoundW-1:0] e_ext;
  logic signed [OffW-1:0]   e_off, v_off, sel_off;
  logic                     ent, del, cand, is_query, v_pos;
  logic [PosW-1:0]          sel;

  assign is_query = (mode_q == MODE_FWD) || (mode_q == MODE_BWD);
  assign v_pos    = !value_q[ValueW-1] && (value_q != '0);
  assign mag      = in_value_i[ValueW-1] ? (~in_value_i + 1'b1) : in_value_i;

  assign e_ext = $signed({{(BoundW-PosW){1'b0}}, rd_data_q});
  assign e_off = $signed({{(OffW-PosW){1'b0}}, rd_data_q});
  assign v_off = OffW'(value_q);
  assign ent   = rd_en_q && rd_valid_q;
  assign del   = ent && (mode_q == MODE_VALUE) && (e_ext > lo_q) && (e_ext < hi_q);

  always_comb begin
    if (mode_q == MODE_FWD) begin
      cand = (e_off > v_off) && (!hit_q || rd_data_q < best_q);
    end else begin
      cand = (e_off < v_off) && (!hit_q || rd_data_q > best_q);
    end
  end

  always_comb begin
    if (hit_q) begin
      sel = best_q;
    end else if (mode_q == MODE_FWD) begin
      sel = mx_q;
    end else begin
      sel = mn_q;
    end
  end
  assign sel_off = $signed({{(OffW-PosW){1'b0}}, sel});

  assign status_o.scan_last = (addr_q == AW'(DEPTH - 1));
  assign status_o.is_query  = is_query;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  // Entry store: one read port for the scan, one write port for the insert.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[addr_q];
    if (cmd_i.finish && mode_q == MODE_VALUE && v_pos && free_found_q) begin
      mem[free_idx_q] <= value_q[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      dropped_q  <= 1'b0;
      prec_q     <= PrecReset;
      rd_en_q    <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        prec_q <= cfg_data_i;
      end
      rd_en_q    <= cmd_i.issue;
      rd_valid_q <= valid_q[addr_q];
      if (del) begin
        valid_q[rd_idx_q] <= 1'b0;
      end
      if (cmd_i.finish && mode_q == MODE_VALUE && v_pos) begin
        if (free_found_q) begin
          valid_q[free_idx_q] <= 1'b1;
        end else begin
          dropped_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (cmd_i.load) begin
      mode_q       <= in_mode_i;
      value_q      <= in_value_i;
      lo_q         <= $signed({2'b00, mag}) - $signed({3'b000, prec_q});
      hi_q         <= $signed({2'b00, mag}) + $signed({3'b000, prec_q});
      addr_q       <= '0;
      any_q        <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (cmd_i.issue && !status_o.scan_last) begin
        addr_q <= addr_q + 1'b1;
      end
      if (rd_en_q && (!rd_valid_q || del) && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= rd_idx_q;
      end
      if (ent) begin
        any_q <= 1'b1;
        if (!any_q || rd_data_q < mn_q) begin
          mn_q <= rd_data_q;
        end
        if (!any_q || rd_data_q > mx_q) begin
          mx_q <= rd_data_q;
        end
        if (cand) begin
          best_q <= rd_data_q;
          hit_q  <= 1'b1;
        end
      end
    end
  end

  // Output register: a result may wait here while the next item is scanned.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish && is_query) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && is_query) begin
      out_found_q    <= any_q;
      out_overflow_q <= dropped_q;
      out_position_q <= any_q ? sel : '0;
      out_offset_q   <= any_q ? OffW'(sel_off - v_off) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_found_o    = out_found_q;
  assign out_position_o = out_position_q;
  assign out_offset_o   = out_offset_q;
  assign out_overflow_o = out_overflow_q;

endmodule

// ===== sv/tolerant_position_set_search_core.sv =====
// Tolerant position set search core.
// Input stream: tuser carries the mode (add/remove, search forward, search
// backward), tdata the signed position or target in tenths. A value
// transaction removes stored entries within the precision of its magnitude
// and inserts it when positive; it gives no result. A search transaction
// gives one result transaction on the output stream.
// Configuration: one write channel sets the removal precision (reset 100);
// the user must write it only while the core is idle; the core does not
// enforce this. Each item goes through an accept step, a scan that reads
// the entry memory one read per cycle over all DEPTH entries, a step to
// evaluate the last read, and a final step to insert or load the result
// register. A search result is registered at that final step.
// The result sits in an output register, so the next item is accepted and
// scanned while it waits. If the receiver still stalls when the next search
// finishes, the core holds in its final step and accepts nothing new.
// Reset empties the set, clears the overflow flag and needs no clearing
// pass: entry valid bits are flip-flops.
module tolerant_position_set_search_core
  import tpss_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [23:0]       s_axis_tdata_i,  // [23:0] value
  input  logic [ModeW-1:0]  s_axis_tuser_i,  // [1:0] mode
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [47:0]       m_axis_tdata_o,  // [22:0] position, [47:23] offset
  output logic [1:0]        m_axis_tuser_o,  // [0] found, [1] overflow
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [PrecW-1:0]  cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  tpss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tpss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_mode_i      (s_axis_tuser_i),
    .in_value_i     (s_axis_tdata_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_found_o    (m_axis_tuser_o[0]),
    .out_position_o (m_axis_tdata_o[22:0]),
    .out_offset_o   (m_axis_tdata_o[47:23]),
    .out_overflow_o (m_axis_tuser_o[1])
  );

`ifndef SYNTHESIS
  a_cmd_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.issue, cmd.finish}))
    else $error("controller issued more than one command");

  a_load_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.issue)
    else $error("scan did not start after an accepted item");

  a_no_result_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.finish && status.is_query) |-> !(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("result register overwritten while stalled");

  a_accept_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> cmd.load)
    else $error("input transaction accepted without a load");
`endif

endmodule
